/* design/hdac_pkg.sv */
// ----------------------------------------------------------------------------
// hdac_pkg
// Shared types and constants of the HID descriptor application classifier.
// ----------------------------------------------------------------------------
package hdac_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 32;
    localparam int unsigned LeftW  = 9;

    // Prefix of a long item
    localparam logic [ByteW-1:0] LongPrefix = 8'hFE;

    // Item types
    localparam logic [1:0] KindMain   = 2'd0;
    localparam logic [1:0] KindGlobal = 2'd1;
    localparam logic [1:0] KindLocal  = 2'd2;

    // Item tags
    localparam logic [3:0] TagUsagePage  = 4'h0;
    localparam logic [3:0] TagUsage      = 4'h0;
    localparam logic [3:0] TagCollection = 4'hA;

    // Size code that stands for four data bytes
    localparam logic [1:0] SizeCodeFour = 2'd3;

    // Collection and usage values
    localparam logic [ValueW-1:0] CollApplication    = 32'h0000_0001;
    localparam logic [ValueW-1:0] PageGenericDesktop = 32'h0000_0001;
    localparam logic [ValueW-1:0] UseMouse           = 32'h0000_0002;
    localparam logic [ValueW-1:0] UseJoystick        = 32'h0000_0004;
    localparam logic [ValueW-1:0] UseGamepad         = 32'h0000_0005;
    localparam logic [ValueW-1:0] UseKeyboard        = 32'h0000_0006;

    typedef struct packed {
        logic gamepad;
        logic keyboard;
        logic mouse;
    } t_flags;

    // One descriptor byte held in the input register
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } t_byte_req;

endpackage

/* design/hdac_in_reg.sv */
// ----------------------------------------------------------------------------
// hdac_in_reg
// Input register: holds one descriptor byte until the parser takes it.
// ----------------------------------------------------------------------------
module hdac_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  hdac_pkg::t_byte_req i_req,
    output logic               o_in_stall,
    input  logic               i_take,
    output logic               o_req_valid,
    output hdac_pkg::t_byte_req o_req
);
    import hdac_pkg::*;

    logic      r_valid;
    t_byte_req r_req;
    logic      w_accept;

    // Stall only while a held request is not taken this cycle
    assign o_in_stall = r_valid && !i_take;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    assign o_req_valid = r_valid;
    assign o_req       = r_req;

endmodule

/* design/hdac_parser.sv */
// ----------------------------------------------------------------------------
// hdac_parser
// Item decoder: walks the descriptor one byte a cycle while i_go is high,
// tracks usage page and local usage, and raises the application flags.
// ----------------------------------------------------------------------------
module hdac_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  hdac_pkg::t_byte_req   i_req,
    output hdac_pkg::t_flags      o_flags
);
    import hdac_pkg::*;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_SHORT,
        PH_LSIZE,
        PH_LSKIP
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [LeftW-1:0]  r_left, n_left;
    logic [1:0]        r_pos, n_pos;
    logic [1:0]        r_kind, n_kind;
    logic [3:0]        r_tag, n_tag;
    logic [ValueW-1:0] r_value, n_value;
    logic [ValueW-1:0] r_page, n_page;
    logic [ValueW-1:0] r_usage, n_usage;
    t_flags            r_flags, n_flags;

    logic              w_finish;
    logic [2:0]        w_size;
    logic [ValueW-1:0] w_lane;
    logic [ByteW-1:0]  w_b;

    assign w_b = i_req.data;

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_pos    = r_pos;
        n_kind   = r_kind;
        n_tag    = r_tag;
        n_value  = r_value;
        n_page   = r_page;
        n_usage  = r_usage;
        n_flags  = r_flags;
        w_finish = 1'b0;
        w_size   = (w_b[1:0] == SizeCodeFour) ? 3'd4 : {1'b0, w_b[1:0]};
        w_lane   = ValueW'(w_b) << {r_pos, 3'b000};

        case (r_phase)
            PH_PREFIX: begin
                if (w_b == LongPrefix) begin
                    n_phase = PH_LSIZE;
                end else begin
                    n_kind  = w_b[3:2];
                    n_tag   = w_b[7:4];
                    n_value = '0;
                    n_pos   = '0;
                    n_left  = LeftW'(w_size);
                    if (w_size == 3'd0) begin
                        w_finish = 1'b1;
                    end else begin
                        n_phase = PH_SHORT;
                    end
                end
            end
            PH_SHORT: begin
                n_value = r_value | w_lane;
                n_pos   = r_pos + 2'd1;
                n_left  = r_left - LeftW'(1);
                w_finish = (n_left == '0);
            end
            PH_LSIZE: begin
                n_left  = LeftW'(w_b) + LeftW'(1);
                n_phase = PH_LSKIP;
            end
            PH_LSKIP: begin
                n_left = r_left - LeftW'(1);
                if (n_left == '0) begin
                    n_phase = PH_PREFIX;
                end
            end
            default: begin
                n_phase = PH_PREFIX;
            end
        endcase

        // Apply a completed item
        if (w_finish) begin
            n_phase = PH_PREFIX;
            if (n_kind == KindGlobal && n_tag == TagUsagePage) begin
                n_page = n_value;
            end else if (n_kind == KindLocal && n_tag == TagUsage) begin
                n_usage = n_value;
            end else if (n_kind == KindMain) begin
                if (n_tag == TagCollection && n_value == CollApplication &&
                    r_page == PageGenericDesktop) begin
                    if (r_usage == UseGamepad || r_usage == UseJoystick) begin
                        n_flags.gamepad = 1'b1;
                    end else if (r_usage == UseKeyboard) begin
                        n_flags.keyboard = 1'b1;
                    end else if (r_usage == UseMouse) begin
                        n_flags.mouse = 1'b1;
                    end
                end
                n_usage = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_req.last)) begin
            r_phase <= PH_PREFIX;
            r_left  <= '0;
            r_pos   <= '0;
            r_kind  <= '0;
            r_tag   <= '0;
            r_value <= '0;
            r_page  <= '0;
            r_usage <= '0;
            r_flags <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_kind  <= n_kind;
            r_tag   <= n_tag;
            r_value <= n_value;
            r_page  <= n_page;
            r_usage <= n_usage;
            r_flags <= n_flags;
        end
    end

    // Flags after this byte is decoded
    assign o_flags = n_flags;

endmodule

/* design/hdac_out_reg.sv */
// ----------------------------------------------------------------------------
// hdac_out_reg
// Result register: holds the three flags until the receiver takes them.
// ----------------------------------------------------------------------------
module hdac_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hdac_pkg::t_flags  i_flags,
    input  logic              i_out_stall,
    output logic              o_free,
    output logic              o_out_valid,
    output hdac_pkg::t_flags  o_flags
);
    import hdac_pkg::*;

    logic   r_valid;
    t_flags r_flags;

    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags <= i_flags;
        end
    end

    assign o_out_valid = r_valid;
    assign o_flags     = r_flags;

endmodule

/* design/hid_descriptor_application_classifier_core.sv */
// ----------------------------------------------------------------------------
// hid_descriptor_application_classifier_core
// Classifies an HID report descriptor stream as gamepad, keyboard and mouse.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_data_byte, i_last_byte
//  out     | output    | o_out_valid/i_out_stall | o_has_gamepad, _keyboard, _mouse
//
//  One byte a cycle unless a last byte waits: a byte is registered and
//  decoded in the next cycle, a last byte only once the result slot is free,
//  and a last byte places its result in the output register in that same cycle.
//  Reset (synchronous, active low) clears the parser and both valid flags.
//  A stalled result holds only a following last byte; other bytes go on.
// ----------------------------------------------------------------------------
module hid_descriptor_application_classifier_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [hdac_pkg::ByteW-1:0] i_data_byte,
    input  logic                       i_last_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_has_gamepad,
    output logic                       o_has_keyboard,
    output logic                       o_has_mouse
);
    import hdac_pkg::*;

    t_byte_req w_in_req;
    t_byte_req w_req;
    logic      w_req_valid;
    logic      w_out_free;
    logic      w_go;
    t_flags    w_flags;
    t_flags    w_out_flags;

    assign w_in_req.data = i_data_byte;
    assign w_in_req.last = i_last_byte;

    // Decode a request unless it is a last byte with the result slot full
    assign w_go = w_req_valid && (!w_req.last || w_out_free);

    hdac_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req       (w_in_req),
        .o_in_stall  (o_in_stall),
        .i_take      (w_go),
        .o_req_valid (w_req_valid),
        .o_req       (w_req)
    );

    hdac_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_req   (w_req),
        .o_flags (w_flags)
    );

    hdac_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_go && w_req.last),
        .i_flags     (w_flags),
        .i_out_stall (i_out_stall),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .o_flags     (w_out_flags)
    );

    assign o_has_gamepad  = w_out_flags.gamepad;
    assign o_has_keyboard = w_out_flags.keyboard;
    assign o_has_mouse    = w_out_flags.mouse;

endmodule
